FILE: sv/ctvf_pkg.sv
package ctvf_pkg;

    // Request kinds.
    localparam logic [2:0] REQ_FORMAT     = 3'd0;
    localparam logic [2:0] REQ_WRITE_TAPE = 3'd1;
    localparam logic [2:0] REQ_CMD_START  = 3'd2;
    localparam logic [2:0] REQ_LINE_DONE  = 3'd3;
    localparam logic [2:0] REQ_REWIND     = 3'd4;

    // Reported paper motion.
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_FF   = 2'd1;
    localparam logic [1:0] ACT_LF   = 2'd2;
    localparam logic [1:0] ACT_CR   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PRINTER_MODEL = 1'b0;
    localparam logic CFG_TAPE_LENGTH   = 1'b1;

    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] TAPE_LENGTH_RESET = 9'd1;

    // Format byte codes and field masks.
    localparam logic [7:0] CODE_INHIBIT  = 8'h60;
    localparam logic [7:0] CODE_SPACE    = 8'hC0;
    localparam logic [7:0] CODE_SKIP     = 8'hF0;
    localparam logic [7:0] MASK_LOW7     = 8'h7F;
    localparam logic [7:0] SPACE_IGN_M1  = 8'h20;
    localparam logic [7:0] SPACE_CNT_M0  = 8'h0F;
    localparam logic [7:0] SPACE_CNT_M1  = 8'h07;
    localparam logic [7:0] SKIP_CHAN_M0  = 8'h01;
    localparam logic [7:0] SKIP_CHAN_M1  = 8'h07;

    // Tape line 0 reads as all channels punched until it is written.
    localparam logic [7:0] TAPE_HEAD_RESET = 8'hFF;

    localparam logic [2:0] CHAN_BOTTOM = 3'd0;
    localparam logic [2:0] CHAN_TOP    = 3'd1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] format_char;
        logic [7:0] tape_index;
        logic [7:0] tape_mask;
    } ctvf_req_t;

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] feed_count;
        logic       runaway_status;
        logic [7:0] position_now;
        logic       inhibit_status;
    } ctvf_rsp_t;

    typedef struct packed {
        logic load;
        logic finish_simple;
        logic reduce_start;
        logic reduce_step;
        logic scan_init;
        logic scan_retry;
        logic scan_run;
        logic finish_scan;
    } ctvf_cmd_t;

    typedef struct packed {
        logic scan_op;
        logic reduce_last;
        logic hit;
        logic exhausted;
        logic mode_space;
    } ctvf_status_t;

endpackage

FILE: sv/ctvf_ctrl.sv
module ctvf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output ctvf_pkg::ctvf_cmd_t    cmd,
    input  ctvf_pkg::ctvf_status_t status
);
    import ctvf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_SETUP  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.scan_op)
                begin
                    cmd.reduce_start = 1'b1;
                    state_next       = ST_REDUCE;
                end
                else
                begin
                    cmd.finish_simple = 1'b1;
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (status.reduce_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // A bottom-of-form hit during a space turns into a skip to top of form.
                if (status.hit && status.mode_space)
                begin
                    cmd.scan_retry = 1'b1;
                end
                else if (status.hit || status.exhausted)
                begin
                    cmd.finish_scan = 1'b1;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: sv/ctvf_datapath.sv
module ctvf_datapath #(
    parameter int TAPE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctvf_pkg::ctvf_cmd_t                  cmd,
    output ctvf_pkg::ctvf_status_t               status,
    input  ctvf_pkg::ctvf_req_t                  request,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [ctvf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ctvf_pkg::ctvf_rsp_t                  result
);
    import ctvf_pkg::*;

    // Only lines 0..STORE_DEPTH-1 (at most 0..255) can ever be written; lines above that read as blank.
    localparam int STORE_DEPTH = (TAPE_DEPTH < 256) ? TAPE_DEPTH : 256;
    localparam int LEN_MAX     = (TAPE_DEPTH < 511) ? TAPE_DEPTH : 511;
    localparam int POS_W       = $clog2(LEN_MAX);
    localparam int LEN_W       = $clog2(LEN_MAX + 1);
    localparam int CNT_W       = (LEN_W > 4) ? LEN_W : 4;
    localparam int SAW         = $clog2(STORE_DEPTH);
    localparam int DW          = LEN_W + POS_W - 1;
    localparam int KW          = $clog2(POS_W + 1);

    logic [7:0]             tape_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;

    ctvf_req_t              item_reg;
    logic                   model_reg;
    logic [8:0]             tlen_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   inhibit_reg;
    logic                   runaway_reg;
    logic [POS_W-1:0]       rem_reg;
    logic [DW-1:0]          div_reg;
    logic [KW-1:0]          step_reg;
    logic [POS_W-1:0]       addr_reg;
    logic [CNT_W-1:0]       iss_reg;
    logic [CNT_W-1:0]       lim_reg;
    logic [2:0]             chan_reg;
    logic                   mode_space_reg;
    logic                   pend_valid_reg;
    logic [CNT_W-1:0]       pend_idx_reg;
    logic [POS_W-1:0]       pend_addr_reg;
    logic [7:0]             mem_q_reg;
    logic                   mem_hit_reg;
    logic                   zero_reg;
    logic                   oob_reg;
    ctvf_rsp_t              result_reg;

    logic [7:0]       fc;
    logic [7:0]       cnt_mask;
    logic [7:0]       ign_mask;
    logic [7:0]       chan_mask;
    logic             is_inh;
    logic             is_space;
    logic             is_skip;
    logic [CNT_W-1:0] space_cnt;
    logic [2:0]       skip_chan;
    logic [8:0]       len9;
    logic [LEN_W-1:0] len;
    logic [7:0]       line_data;
    logic             hit;
    logic             exhausted;
    logic             rd_en;
    logic [SAW-1:0]   raddr;
    logic             raddr_oob;
    logic [POS_W:0]   addr_inc;
    logic [POS_W-1:0] addr_nx;
    logic             rem_ge;
    logic [POS_W-1:0] rem_sub;
    logic             mem_we;
    logic [SAW-1:0]   widx;
    logic [POS_W-1:0] pos_next;
    logic             inhibit_next;
    logic             runaway_next;
    logic [1:0]       act_next;
    logic [8:0]       feeds_next;
    logic             land_top;

    // Format byte decode; the second model ignores bit 5 of a space byte.
    always_comb
    begin
        fc        = item_reg.format_char;
        cnt_mask  = model_reg ? SPACE_CNT_M1 : SPACE_CNT_M0;
        ign_mask  = model_reg ? SPACE_IGN_M1 : 8'h00;
        chan_mask = model_reg ? SKIP_CHAN_M1 : SKIP_CHAN_M0;
        is_inh    = ((fc & MASK_LOW7) == CODE_INHIBIT);
        is_space  = !is_inh && ((fc & ~(ign_mask | cnt_mask)) == CODE_SPACE);
        is_skip   = !is_inh && !is_space && ((fc & ~chan_mask) == CODE_SKIP);
        space_cnt = CNT_W'(fc & cnt_mask);
        skip_chan = 3'(fc & chan_mask);
    end

    // Effective loop length: zero counts as one, clamp to the tape depth.
    always_comb
    begin
        if (tlen_reg == 9'd0)
        begin
            len9 = 9'd1;
        end
        else if (tlen_reg > 9'(LEN_MAX))
        begin
            len9 = 9'(LEN_MAX);
        end
        else
        begin
            len9 = tlen_reg;
        end
        len = LEN_W'(len9);
    end

    // Tape read port and scan bookkeeping. Each read fetches the line after the one
    // the scan stands on, so the first read is one line past the reduced position.
    always_comb
    begin
        line_data = oob_reg ? 8'h00 :
                    mem_hit_reg ? mem_q_reg :
                    (zero_reg ? TAPE_HEAD_RESET : 8'h00);
        hit       = pend_valid_reg && line_data[chan_reg];
        exhausted = !pend_valid_reg && (iss_reg == lim_reg);
        rd_en     = cmd.scan_run && (iss_reg < lim_reg);
        addr_inc  = (POS_W + 1)'(addr_reg) + (POS_W + 1)'(1);
        addr_nx   = (addr_inc >= (POS_W + 1)'(len)) ? '0 : addr_inc[POS_W-1:0];
        raddr     = addr_nx[SAW-1:0];
        raddr_oob = ({1'b0, addr_nx} >= (POS_W + 1)'(STORE_DEPTH));
        rem_ge    = (DW'(rem_reg) >= div_reg);
        rem_sub   = rem_reg - div_reg[POS_W-1:0];
        mem_we    = cmd.finish_simple && (item_reg.req_type == REQ_WRITE_TAPE) &&
                    (9'(item_reg.tape_index) < 9'(STORE_DEPTH));
        widx      = item_reg.tape_index[SAW-1:0];
        land_top  = !mode_space_reg && line_data[CHAN_TOP];
    end

    always_comb
    begin
        status.scan_op     = (item_reg.req_type == REQ_FORMAT) && (is_space || is_skip);
        status.reduce_last = (step_reg == '0);
        status.hit         = hit;
        status.exhausted   = exhausted;
        status.mode_space  = mode_space_reg;
    end

    // Next architectural state and the result for the item being finished.
    always_comb
    begin
        pos_next     = pos_reg;
        inhibit_next = inhibit_reg;
        runaway_next = runaway_reg;
        act_next     = ACT_NONE;
        feeds_next   = 9'd0;
        if (cmd.finish_simple)
        begin
            unique case (item_reg.req_type)
                REQ_FORMAT:
                begin
                    if (is_inh)
                    begin
                        inhibit_next = 1'b1;
                    end
                end
                REQ_CMD_START:
                begin
                    inhibit_next = 1'b0;
                    runaway_next = 1'b0;
                end
                REQ_LINE_DONE:
                begin
                    if (inhibit_reg)
                    begin
                        act_next = ACT_CR;
                    end
                    else
                    begin
                        act_next   = ACT_LF;
                        feeds_next = 9'd1;
                    end
                end
                REQ_REWIND:
                begin
                    pos_next = '0;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
        else if (cmd.finish_scan)
        begin
            // A skip that finds nothing goes once around the loop and flags runaway.
            pos_next = hit ? pend_addr_reg : addr_reg;
            if (!mode_space_reg && !hit)
            begin
                runaway_next = 1'b1;
            end
            if (land_top)
            begin
                act_next = ACT_FF;
            end
            else
            begin
                act_next   = ACT_LF;
                feeds_next = hit ? 9'(pend_idx_reg) : 9'(lim_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg      <= 1'b0;
            tlen_reg       <= TAPE_LENGTH_RESET;
            pos_reg        <= '0;
            inhibit_reg    <= 1'b0;
            runaway_reg    <= 1'b0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_PRINTER_MODEL)
                begin
                    model_reg <= cfg_data[0];
                end
                else
                begin
                    tlen_reg <= cfg_data;
                end
            end
            pos_reg     <= pos_next;
            inhibit_reg <= inhibit_next;
            runaway_reg <= runaway_next;
            if (mem_we)
            begin
                valid_reg[widx] <= 1'b1;
            end
            if (cmd.scan_init || cmd.scan_retry)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pend_valid_reg <= (iss_reg < lim_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape_mem[widx] <= item_reg.tape_mask;
        end
        if (rd_en)
        begin
            mem_q_reg   <= tape_mem[raddr];
            mem_hit_reg <= valid_reg[raddr];
            zero_reg    <= (addr_nx == '0);
            oob_reg     <= raddr_oob;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= request;
        end
        // Position modulo loop length, one quotient bit per cycle.
        if (cmd.reduce_start)
        begin
            rem_reg  <= pos_reg;
            div_reg  <= DW'(len) << (POS_W - 1);
            step_reg <= KW'(POS_W - 1);
        end
        if (cmd.reduce_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sub;
            end
            div_reg  <= div_reg >> 1;
            step_reg <= step_reg - KW'(1);
        end
        if (cmd.scan_init)
        begin
            addr_reg       <= rem_reg;
            iss_reg        <= '0;
            lim_reg        <= is_space ? space_cnt : CNT_W'(len);
            chan_reg       <= is_space ? CHAN_BOTTOM : skip_chan;
            mode_space_reg <= is_space;
        end
        if (cmd.scan_retry)
        begin
            addr_reg       <= rem_reg;
            iss_reg        <= '0;
            lim_reg        <= CNT_W'(len);
            chan_reg       <= CHAN_TOP;
            mode_space_reg <= 1'b0;
        end
        if (rd_en)
        begin
            addr_reg      <= addr_nx;
            iss_reg       <= iss_reg + CNT_W'(1);
            pend_idx_reg  <= iss_reg + CNT_W'(1);
            pend_addr_reg <= addr_nx;
        end
        if (cmd.finish_simple || cmd.finish_scan)
        begin
            result_reg.action         <= act_next;
            result_reg.feed_count     <= feeds_next;
            result_reg.runaway_status <= runaway_next;
            result_reg.position_now   <= 8'(pos_next);
            result_reg.inhibit_status <= inhibit_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: sv/carriage_tape_vertical_format.sv
// Carriage control tape vertical format unit. An item is taken on a clock edge with start
// high and busy low; exactly one result follows, shown on result for the single cycle in
// which done is high, and the receiver cannot stall it, so it must capture the result in
// that cycle. Configuration writes (printer model, tape length) are accepted at any time
// through cfg_valid and cfg_ready, which is always high, but are meant to be made while
// the block is idle. Tape writes, command start, line printed, rewind, inhibit bytes and
// unrecognized bytes pass through the decode state straight to done. A space or skip byte
// passes through decode, then reduces the position modulo the loop length in one step per
// position bit (8 position bits at the default depth), then a setup state, then a scan that
// reads the tape lines: up to the space count for a space, up to the loop length for a skip,
// and both in turn when a space meets bottom of form and becomes a skip to top of form; such
// a space restarts its scan from the reduced position. The scan is paced by the single tape
// memory read port, which reads one tape line per cycle. A new item may be started in the
// cycle in which done is high. There is no clearing pass after reset.
module carriage_tape_vertical_format #(
    parameter int TAPE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ctvf_pkg::ctvf_req_t             request,
    output logic                           done,
    output ctvf_pkg::ctvf_rsp_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [ctvf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ctvf_pkg::*;

    ctvf_cmd_t    cmd;
    ctvf_status_t status;

    // The configuration registers never push back, so every write transfer completes at once.
    assign cfg_ready = 1'b1;

    // The controller sequences decode, position reduction and the tape scan.
    ctvf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // The datapath holds the tape memory, position, flags and the result register.
    ctvf_datapath #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .request   (request),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

FILE: sv/ctvf_checker.sv
module ctvf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input ctvf_pkg::ctvf_rsp_t result
);
    import ctvf_pkg::*;

    // A result only closes a transfer that was being worked on.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding busy period");

    // Work never ends without a result.
    a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_start_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_feeds_only_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.action != ACT_LF)) |-> (result.feed_count == 9'd0))
        else $error("feed count reported without a line feed action");

    a_cr_needs_inhibit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.action == ACT_CR)) |-> result.inhibit_status)
        else $error("carriage return reported while not inhibited");

endmodule

bind carriage_tape_vertical_format ctvf_checker u_ctvf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
